// ===== src/dersig_pkg.sv =====
// Package for the DER signature decoder: tags, phase and status codes, sizes.
`default_nettype none

package dersig_pkg;

  localparam int INT_BYTES_DEF = 32;
  localparam int HALF_BYTES    = 32;
  localparam int RES_BYTES     = 2 * HALF_BYTES;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 24;

  localparam logic [7:0] TAG_SEQUENCE    = 8'h30;
  localparam logic [7:0] TAG_INTEGER     = 8'h02;
  localparam logic [7:0] LEN_UNSUPPORTED = 8'hfd;

  typedef logic [2:0] phase_t;
  localparam phase_t PH_SEQ   = 3'd0;
  localparam phase_t PH_TOTAL = 3'd1;
  localparam phase_t PH_RTAG  = 3'd2;
  localparam phase_t PH_RLEN  = 3'd3;
  localparam phase_t PH_RDATA = 3'd4;
  localparam phase_t PH_STAG  = 3'd5;
  localparam phase_t PH_SLEN  = 3'd6;
  localparam phase_t PH_SDATA = 3'd7;

  typedef logic [3:0] status_t;
  localparam status_t ST_OK        = 4'd0;
  localparam status_t ST_BAD_SEQ   = 4'd1;
  localparam status_t ST_BAD_RTAG  = 4'd2;
  localparam status_t ST_ZERO_RLEN = 4'd3;
  localparam status_t ST_BAD_STAG  = 4'd4;
  localparam status_t ST_ZERO_SLEN = 4'd5;
  localparam status_t ST_MISMATCH  = 4'd6;
  localparam status_t ST_TRUNC     = 4'd7;
  localparam status_t ST_TOO_LONG  = 4'd8;
  localparam status_t ST_BAD_LEN   = 4'd9;

endpackage

`default_nettype wire

// ===== src/der_signature_decoder.sv =====
// DER signature decoder: byte parser, r/s stores and padded 64-byte emitter.
//
//   channel | fields                                  | transaction
//   in_     | in_byte, in_last                        | one encoded byte
//   out_    | out_byte, out_index, status, out_last   | one result byte or status
//
// One byte is taken per cycle while in_tready is high; a byte that causes a status
// result yields one output transaction. The byte that completes s starts a 64-byte
// burst read from the r and s stores, during which in_tready is low. Reset returns
// the parser to the sequence tag. A result waiting on out_tready holds in_tready low
// and stretches the burst.
`default_nettype none

module der_signature_decoder #(
  parameter int INT_BYTES = dersig_pkg::INT_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [dersig_pkg::IN_TDATA_W-1:0]  in_tdata,  // [7:0] in_byte
  input  wire logic                               in_tlast,  // in_last
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [dersig_pkg::OUT_TDATA_W-1:0]      out_tdata, // [7:0] out_byte,
                                                             // [13:8] out_index,
                                                             // [17:14] status
  output logic                                    out_tlast  // out_last
);
  import dersig_pkg::*;

  localparam int LIMIT = (INT_BYTES < HALF_BYTES) ? INT_BYTES : HALF_BYTES;
  localparam int LW    = $clog2(LIMIT + 2);
  localparam int CW    = $clog2(LIMIT + 1);
  localparam int IW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam logic [7:0]    LEN_MAX  = 8'(LIMIT + 1);
  localparam logic [LW-1:0] LEN_BIG  = LW'(LIMIT + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(LIMIT);

  phase_t        phase_r, phase_nxt;
  logic          skip_r, skip_nxt;
  logic [7:0]    tot_r, tot_nxt;
  logic [LW-1:0] rlen_r, rlen_nxt, slen_r, slen_nxt, rem_r, rem_nxt;
  logic [CW-1:0] rcnt_r, rcnt_nxt, scnt_r, scnt_nxt;
  logic [7:0]    r_mem [LIMIT];
  logic [7:0]    s_mem [LIMIT];

  logic          burst_r;
  logic [5:0]    k_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic [5:0]    out_index_r;
  status_t       status_r;
  logic          out_last_r;

  logic          out_free, in_acc, in_last;
  logic [7:0]    b;
  status_t       err;
  logic          done, wr_r, wr_s, emit_status;
  logic [LW-1:0] cur_len;
  logic [CW-1:0] cur_cnt;
  logic          first;
  logic [6:0]    total;

  logic [CW-1:0] rd_cnt;
  logic [6:0]    rd_sum;
  logic [IW-1:0] rd_idx;
  logic          rd_hit;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !burst_r && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata[7:0];
  assign in_last   = in_tlast;

  assign cur_len = (phase_r == PH_SDATA) ? slen_r : rlen_r;
  assign cur_cnt = (phase_r == PH_SDATA) ? scnt_r : rcnt_r;
  assign first   = (rem_r == cur_len);
  assign total   = 7'd4 + 7'(rlen_r) + 7'(slen_r);

  always_comb begin
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    tot_nxt     = tot_r;
    rlen_nxt    = rlen_r;
    slen_nxt    = slen_r;
    rem_nxt     = rem_r;
    rcnt_nxt    = rcnt_r;
    scnt_nxt    = scnt_r;
    err         = ST_OK;
    done        = 1'b0;
    wr_r        = 1'b0;
    wr_s        = 1'b0;
    emit_status = 1'b0;
    if (skip_r) begin
      if (in_last) begin
        skip_nxt  = 1'b0;
        phase_nxt = PH_SEQ;
      end
    end else begin
      unique case (phase_r) inside
        PH_SEQ: begin
          tot_nxt  = '0;
          rlen_nxt = '0;
          slen_nxt = '0;
          rem_nxt  = '0;
          rcnt_nxt = '0;
          scnt_nxt = '0;
          if (b != TAG_SEQUENCE) err = ST_BAD_SEQ;
          else phase_nxt = PH_TOTAL;
        end
        PH_TOTAL: begin
          if (b >= LEN_UNSUPPORTED) err = ST_BAD_LEN;
          else begin
            tot_nxt   = b;
            phase_nxt = PH_RTAG;
          end
        end
        PH_RTAG, PH_STAG: begin
          if (b != TAG_INTEGER) err = (phase_r == PH_RTAG) ? ST_BAD_RTAG : ST_BAD_STAG;
          else phase_nxt = (phase_r == PH_RTAG) ? PH_RLEN : PH_SLEN;
        end
        PH_RLEN, PH_SLEN: begin
          if (b >= LEN_UNSUPPORTED) err = ST_BAD_LEN;
          else if (b == 8'h00) err = (phase_r == PH_RLEN) ? ST_ZERO_RLEN : ST_ZERO_SLEN;
          else if (b > LEN_MAX) err = ST_TOO_LONG;
          else begin
            rem_nxt = b[LW-1:0];
            if (phase_r == PH_RLEN) begin
              rlen_nxt  = b[LW-1:0];
              phase_nxt = PH_RDATA;
            end else begin
              slen_nxt  = b[LW-1:0];
              phase_nxt = PH_SDATA;
            end
          end
        end
        PH_RDATA, PH_SDATA: begin
          rem_nxt = rem_r - 1'b1;
          if (first && b == 8'h00) begin
            err = ST_OK;
          end else if (first && cur_len == LEN_BIG) begin
            err = ST_TOO_LONG;
          end else if (cur_cnt < CNT_FULL) begin
            if (phase_r == PH_RDATA) begin
              wr_r     = 1'b1;
              rcnt_nxt = rcnt_r + 1'b1;
            end else begin
              wr_s     = 1'b1;
              scnt_nxt = scnt_r + 1'b1;
            end
          end
          if (err == ST_OK && rem_nxt == '0) begin
            if (phase_r == PH_RDATA) phase_nxt = PH_STAG;
            else if (tot_r != {1'b0, total}) err = ST_MISMATCH;
            else done = 1'b1;
          end
        end
        default: phase_nxt = PH_SEQ;
      endcase
      if (err != ST_OK) begin
        phase_nxt   = PH_SEQ;
        skip_nxt    = !in_last;
        emit_status = 1'b1;
      end else if (done) begin
        phase_nxt = PH_SEQ;
        skip_nxt  = !in_last;
      end else if (in_last) begin
        phase_nxt   = PH_SEQ;
        err         = ST_TRUNC;
        emit_status = 1'b1;
      end
    end
  end

  assign rd_cnt = k_r[5] ? scnt_r : rcnt_r;
  assign rd_sum = 7'(k_r[4:0]) + 7'(rd_cnt);
  assign rd_hit = (rd_sum >= 7'(HALF_BYTES));
  assign rd_idx = rd_sum[IW-1:0];

  always_ff @(posedge clk) begin
    if (in_acc && wr_r) r_mem[cur_cnt[IW-1:0]] <= b;
    if (in_acc && wr_s) s_mem[cur_cnt[IW-1:0]] <= b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEQ;
      skip_r      <= 1'b0;
      tot_r       <= '0;
      rlen_r      <= '0;
      slen_r      <= '0;
      rem_r       <= '0;
      rcnt_r      <= '0;
      scnt_r      <= '0;
      burst_r     <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        skip_r  <= skip_nxt;
        tot_r   <= tot_nxt;
        rlen_r  <= rlen_nxt;
        slen_r  <= slen_nxt;
        rem_r   <= rem_nxt;
        rcnt_r  <= rcnt_nxt;
        scnt_r  <= scnt_nxt;
        if (emit_status) out_valid_r <= 1'b1;
        else if (out_tready) out_valid_r <= 1'b0;
        if (done) begin
          burst_r <= 1'b1;
          k_r     <= '0;
        end
      end else if (burst_r && out_free) begin
        out_valid_r <= 1'b1;
        k_r         <= k_r + 1'b1;
        if (k_r == 6'(RES_BYTES - 1)) burst_r <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc && emit_status) begin
      out_byte_r  <= '0;
      out_index_r <= '0;
      status_r    <= err;
      out_last_r  <= 1'b1;
    end else if (!in_acc && burst_r && out_free) begin
      if (!rd_hit) out_byte_r <= '0;
      else if (k_r[5]) out_byte_r <= s_mem[rd_idx];
      else out_byte_r <= r_mem[rd_idx];
      out_index_r <= k_r;
      status_r    <= ST_OK;
      out_last_r  <= (k_r == 6'(RES_BYTES - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, status_r, out_index_r, out_byte_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
